>>> rtl/core/sha256_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the streaming SHA-256 core.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned DigestMax  = 8;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LenStart   = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_LEN,
    ST_EMIT
  } ctrl_state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic       load_byte;   // write the input byte and count it
    logic       put_pad;     // write 0x80 at the fill position
    logic       put_len;     // write the length into the block tail
    logic       start_block; // copy hash into working vars, clear round counter
    logic       do_round;    // run one round
    logic       add_hash;    // fold working vars into hash, clear block
    logic       reset_msg;   // restore IVs, clear length and fill
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic       block_full;  // fill count wrapped on this byte
    logic       last_round;  // round counter at 63
    logic       need_extra;  // pad does not leave room for the length
  } dp_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[idx];
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[idx];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/sha256_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: loads bytes, runs compressions, pads and emits the digest.
// ----------------------------------------------------------------------------
module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     byte_valid_i,
  input  wire logic     eom_i,
  input  wire logic [3:0] digest_words_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic [2:0]    word_idx_o,
  output logic          last_word_o
);

  ctrl_state_e state_q, state_d;
  logic        fin_q, fin_d;     // a finish is pending after this block
  logic        extra_q, extra_d; // the length still needs its own block
  logic        emit_q, emit_d;   // the running compression closes the message
  logic [2:0]  widx_q, widx_d;
  logic [2:0]  wlast;

  // clamp the word count to 1..8
  always_comb begin
    if (digest_words_i == 4'd0) wlast = 3'd0;
    else if (digest_words_i > 4'd8) wlast = 3'd7;
    else wlast = 3'(digest_words_i - 4'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
      extra_q <= 1'b0;
      emit_q  <= 1'b0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
      extra_q <= extra_d;
      emit_q  <= emit_d;
      widx_q  <= widx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    extra_d    = extra_q;
    emit_d     = emit_q;
    widx_d     = widx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte = byte_valid_i;
          if (byte_valid_i && stat_i.block_full) begin
            // full block first; pad afterwards if the item ends the message
            cmd_o.start_block = 1'b1;
            fin_d   = eom_i;
            extra_d = 1'b0;
            state_d = ST_ROUND;
          end else if (eom_i) begin
            state_d = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        // pad and maybe the length, then compress
        cmd_o.put_pad     = 1'b1;
        cmd_o.put_len     = !stat_i.need_extra;
        cmd_o.start_block = 1'b1;
        extra_d = stat_i.need_extra;
        fin_d   = 1'b0;
        emit_d  = 1'b1;
        widx_d  = '0;
        state_d = ST_ROUND;
      end
      ST_LEN: begin
        // length-only block after a pad that left no room
        cmd_o.put_len     = 1'b1;
        cmd_o.start_block = 1'b1;
        extra_d = 1'b0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.do_round = 1'b1;
        if (stat_i.last_round) begin
          cmd_o.add_hash = 1'b1;
          if (fin_q) state_d = ST_FINAL;
          else if (extra_q) state_d = ST_LEN;
          else if (emit_q) begin
            emit_d  = 1'b0;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == wlast) begin
            cmd_o.reset_msg = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign word_idx_o  = widx_q;
  assign last_word_o = (widx_q == wlast);

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_emit_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept during emit");
`endif

endmodule
`default_nettype wire

>>> rtl/core/sha256_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_dp
// Datapath: block buffer, length counter, schedule, round unit and hash.
// ----------------------------------------------------------------------------
module sha256_dp
  import sha256_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire dp_cmd_t    cmd_i,
  input  wire logic [7:0] data_i,
  input  wire logic [2:0] word_idx_i,
  output dp_stat_t        stat_o,
  output logic [31:0]     digest_o
);

  // block buffer held as sixteen big-endian words
  logic [31:0] blk_q [BlockBytes/4];
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] vn [8];
  logic [5:0]  rnd_q;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // replace one byte lane of a word, lane 0 is the most significant
  function automatic logic [31:0] put_byte(input logic [31:0] word, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = word;
    case (lane)
      2'd0:    r[31:24] = b;
      2'd1:    r[23:16] = b;
      2'd2:    r[15:8]  = b;
      2'd3:    r[7:0]   = b;
      default: r = word;
    endcase
    return r;
  endfunction

  // schedule word for this round
  logic [31:0] wt, s0, s1, t1, t2, blk_word;
  logic [3:0]  ri;
  assign ri = rnd_q[3:0];
  always_comb begin
    blk_word = blk_q[ri];
    s0 = rotr(w_q[ri + 4'd1], 7) ^ rotr(w_q[ri + 4'd1], 18) ^ (w_q[ri + 4'd1] >> 3);
    s1 = rotr(w_q[ri + 4'd14], 17) ^ rotr(w_q[ri + 4'd14], 19) ^ (w_q[ri + 4'd14] >> 10);
    wt = (rnd_q < 6'd16) ? blk_word : (w_q[ri] + s0 + s1 + w_q[ri + 4'd9]);
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wt;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // working variables after this round
  always_comb begin
    vn[0] = t1 + t2;
    vn[1] = v_q[0];
    vn[2] = v_q[1];
    vn[3] = v_q[2];
    vn[4] = v_q[3] + t1;
    vn[5] = v_q[4];
    vn[6] = v_q[5];
    vn[7] = v_q[6];
  end

  // control-side counters and hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
    end else begin
      if (cmd_i.load_byte) begin
        fill_q <= fill_q + 6'd1;
        len_q  <= len_q + 64'd8;
      end
      if (cmd_i.start_block) rnd_q <= '0;
      else if (cmd_i.do_round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.add_hash)
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + vn[i];
      if (cmd_i.reset_msg) begin
        fill_q <= '0;
        len_q  <= '0;
        for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      end
    end
  end

  // block buffer with reset to zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BlockBytes/4; i++) blk_q[i] <= '0;
    end else begin
      if (cmd_i.add_hash)
        for (int i = 0; i < BlockBytes/4; i++) blk_q[i] <= '0;
      if (cmd_i.load_byte)
        blk_q[fill_q[5:2]] <= put_byte(blk_q[fill_q[5:2]], fill_q[1:0], data_i);
      if (cmd_i.put_pad)
        blk_q[fill_q[5:2]] <= put_byte(blk_q[fill_q[5:2]], fill_q[1:0], PadByte);
      if (cmd_i.put_len) begin
        blk_q[LenStart[5:2]]        <= len_q[63:32];
        blk_q[LenStart[5:2] + 4'd1] <= len_q[31:0];
      end
    end
  end

  // working variables and schedule
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_block) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.do_round) begin
      w_q[ri] <= wt;
      for (int i = 0; i < 8; i++) v_q[i] <= vn[i];
    end
  end

  assign stat_o.block_full = (fill_q == 6'd63);
  assign stat_o.last_round = (rnd_q == 6'd63);
  assign stat_o.need_extra = (fill_q >= LenStart);
  assign digest_o = h_q[word_idx_i];

endmodule
`default_nettype wire

>>> rtl/core/sha256_stream_hasher_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// Streaming SHA-256 with truncatable digest output.
// ----------------------------------------------------------------------------
// channel  dir  tdata                       tuser       tlast
// s_axis   in   [7:0] data_byte             [0] byte_valid  end_of_message
// m_axis   out  [31:0] digest_word          [2:0] word_index last_word
// cfg      in   [3:0] digest_words on cfg_we_i
// A byte that fills the block starts a compression on the single round
// unit. End of message pads and compresses, plus a length-only block when
// the length needs its own, then one word per cycle out while tready is
// high. Input is held off (tready low) during padding, rounds and emission.
// Reset restores the IVs and clears buffer, length and fill count.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core
  import sha256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] byte_valid
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_index
  output logic             m_axis_tlast,   // last_word
  input  wire logic        cfg_we_i,
  input  wire logic [3:0]  cfg_wdata_i
);

  logic [3:0] dw_q;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  // hold the digest length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dw_q <= 4'd8;
    else if (cfg_we_i) dw_q <= cfg_wdata_i;
  end

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .byte_valid_i(s_axis_tuser), .eom_i(s_axis_tlast),
    .digest_words_i(dw_q), .stat_i(stat), .cmd_o(cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .word_idx_o(m_axis_tuser), .last_word_o(m_axis_tlast)
  );

  sha256_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_i(s_axis_tdata),
    .word_idx_i(m_axis_tuser), .stat_o(stat), .digest_o(m_axis_tdata)
  );

endmodule
`default_nettype wire
